>>> sv/okle_pkg.sv
// Shared types and codes for the ordered key list engine.
// Depends on nothing; imported by okle_mem, okle_ctrl and the top level.
package okle_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FRONT_RD,
    S_FRONT_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_READ_WAIT,
    S_DONE
  } state_e;

  // command word as taken from the input channel
  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic signed [KeyW-1:0] key;
    logic [PosW-1:0]        position;
  } cmd_t;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    status_e                status;
    logic [CountW-1:0]      entry_count;
    logic signed [KeyW-1:0] value;
  } res_t;

endpackage

>>> sv/ordered_key_list_engine.sv
// Ordered key list engine: top level with stream ports and output register.
// Depends on okle_pkg, okle_mem and okle_ctrl.
//
// Use: a control processor sends command words on the s_axis channel and
// takes one result word per command on the m_axis channel.
//   s_axis_tdata_i: command, key, position. m_axis_tdata_o: status,
//   entry_count, value (zero unless a read succeeds).
// Commands: insert at head, append at tail, delete first matching key,
// clear, read the entry at a position. An insert into a full list is dropped
// with status full.
// The sequencer moves or compares one entry at a time through the single-port-read
// entry memory: a read state, then a write or compare state for each entry.
// One command is worked on at a time; s_axis_tready_o is high only while the
// sequencer is idle.
// The output register holds a finished word, so the next command is taken
// while the receiver stalls; the sequencer then waits with its own result
// until the register frees up.
// Reset clears the count and all handshake state; the entry memory is not
// cleared, entries beyond the count are never read.
module ordered_key_list_engine import okle_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [2:0] command, [34:3] key, [38:35] position
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // [1:0] status, [6:2] entry_count, [38:7] value
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  cmd_t                   cmd;
  res_t                   res;
  logic                   res_valid, res_ready;
  logic                   mem_we, mem_re;
  logic [AddrW-1:0]       mem_waddr, mem_raddr;
  logic signed [KeyW-1:0] mem_wdata, mem_rdata;

  logic  m_valid_q;
  res_t  m_res_q;

  assign cmd.command  = s_axis_tdata_i[2:0];
  assign cmd.key      = s_axis_tdata_i[34:3];
  assign cmd.position = s_axis_tdata_i[38:35];

  okle_ctrl #(
    .Capacity(CAPACITY),
    .AddrW   (AddrW),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(s_axis_tvalid_i),
    .cmd_ready_o(s_axis_tready_o),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  okle_mem #(
    .Depth(CAPACITY),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_res_q.value, m_res_q.entry_count, m_res_q.status};

  // sequencer never takes a command while it still holds a result
  a_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && res_valid))
    else $error("command accepted while result pending");

  // a full status always reports a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] == ST_FULL) |->
      m_axis_tdata_o[6:2] == CountW'(CAPACITY))
    else $error("full status with list not full");

  // a handed-over result shows up in the output register next cycle
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid_o)
    else $error("result lost at output register");

  // a command that does not succeed carries a zero value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK) |-> m_axis_tdata_o[38:7] == '0)
    else $error("value on failed command");

endmodule

>>> sv/okle_mem.sv
// Entry storage: one write port, one read port with registered read data.
// Depends on okle_pkg for the key width.
module okle_mem import okle_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic signed [KeyW-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic signed [KeyW-1:0] rdata_o
);

  logic signed [KeyW-1:0] mem_q [Depth];
  logic signed [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/okle_ctrl.sv
// Sequencer of the list engine: key compare for the delete scan and one-entry move per step.
// Depends on okle_pkg; drives the ports of okle_mem.
module okle_ctrl import okle_pkg::*; #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned AddrW    = 4,
  parameter int unsigned CntW     = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  cmd_t                   cmd_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output res_t                   res_o,
  output logic                   mem_we_o,
  output logic [AddrW-1:0]       mem_waddr_o,
  output logic signed [KeyW-1:0] mem_wdata_o,
  output logic                   mem_re_o,
  output logic [AddrW-1:0]       mem_raddr_o,
  input  logic signed [KeyW-1:0] mem_rdata_i
);

  // wide enough for the count and for the 4-bit position and 5-bit count field
  localparam int unsigned ExtW = (CntW > CountW) ? CntW : CountW;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  cmd_t                   cmd_q, cmd_d;
  status_e                status_q, status_d;
  logic signed [KeyW-1:0] value_q, value_d;

  logic [CntW-1:0] idx_prev, idx_next;
  logic [ExtW-1:0] cnt_ext, pos_ext;
  logic            last_idx;
  logic            full;

  assign idx_prev = idx_q - CntW'(1);
  assign idx_next = idx_q + CntW'(1);
  assign cnt_ext  = ExtW'(count_q);
  assign pos_ext  = ExtW'(cmd_q.position);
  assign last_idx = ({1'b0, idx_q} + (CntW+1)'(1)) >= {1'b0, count_q};
  assign full     = count_q >= CntW'(Capacity);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    status_q <= status_d;
    value_q  <= value_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    status_d    = status_q;
    value_d     = value_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_prev[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = ST_OK;
        value_d  = '0;
        state_d  = S_DONE;
        unique case (cmd_q.command)
          CMD_INS_FRONT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              idx_d   = count_q;
              state_d = S_FRONT_RD;
            end
          end
          CMD_INS_BACK: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[AddrW-1:0];
              mem_wdata_o = cmd_q.key;
              count_d     = count_q + CntW'(1);
            end
          end
          CMD_DELETE: begin
            idx_d = '0;
            if (count_q == '0) begin
              status_d = ST_NOT_FOUND;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
          CMD_CLEAR: begin
            count_d = '0;
          end
          CMD_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_d = ST_BAD_INDEX;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_ext[AddrW-1:0];
              state_d     = S_READ_WAIT;
            end
          end
          default: begin
            // unused codes: no operation
          end
        endcase
      end

      // shift toward the tail, from the count down to one, then drop the key at the head
      S_FRONT_RD: begin
        if (idx_q == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          mem_wdata_o = cmd_q.key;
          count_d     = count_q + CntW'(1);
          state_d     = S_DONE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_FRONT_WR;
        end
      end

      S_FRONT_WR: begin
        mem_we_o = 1'b1;
        idx_d    = idx_prev;
        state_d  = S_FRONT_RD;
      end

      S_SCAN_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q[AddrW-1:0];
        state_d     = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (mem_rdata_i == cmd_q.key) begin
          state_d = S_DEL_RD;
        end else if (last_idx) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_next;
          state_d = S_SCAN_RD;
        end
      end

      // close the gap: entry idx takes entry idx+1 up to the tail
      S_DEL_RD: begin
        if (last_idx) begin
          count_d = count_q - CntW'(1);
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_next[AddrW-1:0];
          state_d     = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        mem_we_o = 1'b1;
        idx_d    = idx_next;
        state_d  = S_DEL_RD;
      end

      S_READ_WAIT: begin
        value_d = mem_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.entry_count = cnt_ext[CountW-1:0];
  assign res_o.value       = value_q;

endmodule
